FILE: hw/rtl/mtdc_pkg.sv
// Shared types and constants of the multi-track depth combiner.
package mtdc_pkg;

  // Field and datapath widths.
  localparam int DEPTH_W    = 32;
  localparam int NUM_TRACKS = 8;
  localparam int SUM_W      = 35;
  localparam int RANGE_W    = 33;
  localparam int DIV_W      = 35;
  localparam int COUNT_W    = 4;
  localparam int DRAW_W     = 15;

  // Linear congruential generator constants.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_SEED  = 2'd2;

  // Combine rules.
  typedef enum logic [1:0] {
    RULE_MIN  = 2'd0,
    RULE_MAX  = 2'd1,
    RULE_MEAN = 2'd2,
    RULE_RAND = 2'd3
  } mode_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAW,
    ST_DIV,
    ST_DONE
  } state_e;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] cmp;
    logic signed [SUM_W-1:0]   add;
  } lane_t;

  // Merged minimum, maximum and sum of the active lanes.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] lo;
    logic signed [DEPTH_W-1:0] hi;
    logic signed [SUM_W-1:0]   sum;
  } red_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/mtdc_lane.sv
// One depth lane: masks a track that does not take part in the reduction.
module mtdc_lane #(
  parameter int LANE = 0
) (
  input  logic signed [mtdc_pkg::DEPTH_W-1:0] depth_i,
  input  logic signed [mtdc_pkg::DEPTH_W-1:0] base_i,
  input  logic        [mtdc_pkg::COUNT_W-1:0] count_i,
  output mtdc_pkg::lane_t                     lane_o
);
  import mtdc_pkg::*;

  logic active;

  // Lane zero always takes part; the others only below the track count.
  assign active = (COUNT_W'(LANE) < count_i);

  // An idle lane repeats lane zero for min and max and adds nothing to the sum.
  always_comb begin
    lane_o.cmp = active ? depth_i : base_i;
    lane_o.add = active ? SUM_W'(depth_i) : '0;
  end

endmodule

FILE: hw/rtl/mtdc_merge.sv
// Merging stage: registered min, max and sum tree over all lanes.
module mtdc_merge (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  mtdc_pkg::lane_t [mtdc_pkg::NUM_TRACKS-1:0] lanes_i,
  output mtdc_pkg::red_t                        red_o
);
  import mtdc_pkg::*;

  logic signed [DEPTH_W-1:0] lo1 [4];
  logic signed [DEPTH_W-1:0] hi1 [4];
  logic signed [SUM_W-1:0]   sm1 [4];
  logic signed [DEPTH_W-1:0] lo2 [2];
  logic signed [DEPTH_W-1:0] hi2 [2];
  logic signed [SUM_W-1:0]   sm2 [2];
  red_t red_d, red_q;

  // Three levels of pairwise compare and add.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lo1[k] = (lanes_i[2*k+1].cmp < lanes_i[2*k].cmp) ? lanes_i[2*k+1].cmp
                                                      : lanes_i[2*k].cmp;
      hi1[k] = (lanes_i[2*k+1].cmp > lanes_i[2*k].cmp) ? lanes_i[2*k+1].cmp
                                                      : lanes_i[2*k].cmp;
      sm1[k] = lanes_i[2*k].add + lanes_i[2*k+1].add;
    end
    for (int k = 0; k < 2; k++) begin
      lo2[k] = (lo1[2*k+1] < lo1[2*k]) ? lo1[2*k+1] : lo1[2*k];
      hi2[k] = (hi1[2*k+1] > hi1[2*k]) ? hi1[2*k+1] : hi1[2*k];
      sm2[k] = sm1[2*k] + sm1[2*k+1];
    end
    red_d.lo  = (lo2[1] < lo2[0]) ? lo2[1] : lo2[0];
    red_d.hi  = (hi2[1] > hi2[0]) ? hi2[1] : hi2[0];
    red_d.sum = sm2[0] + sm2[1];
  end

  // The merged result is captured when a beat is taken.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  assign red_o = red_q;

endmodule

FILE: hw/rtl/mtdc_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
module mtdc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtdc_pkg::div_req_t req_i,
  output mtdc_pkg::div_rsp_t rsp_o
);
  import mtdc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[DIV_W+1];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  always_comb begin
    rsp_o.done      = done_q;
    rsp_o.quotient  = quo_q;
    rsp_o.remainder = rem_q;
  end

endmodule

FILE: hw/rtl/multi_track_depth_combiner_unit.sv
// Top level of the multi-track depth combiner.
//
// Each input beat carries eight signed 32-bit track depths; the first
// input_count of them (clamped to 1..MAX_TRACKS) are reduced by per-track
// lanes and a registered merging tree into their minimum, maximum and sum.
// The block takes one beat at a time. Minimum and maximum go from ST_EVAL
// straight to ST_DONE, as does random mode when all depths are equal.
// Mean and random mode with distinct bounds pass through the shared
// one-bit-per-cycle divider (35 steps) in ST_DIV; random first passes
// ST_DRAW, which follows the registered generator step through the 32x32
// multiplier. A stalled result side holds the block in ST_DONE. A
// finished result waits in the output register while the next beat is
// accepted. Writing random_seed reloads the generator state.
module multi_track_depth_combiner_unit #(
  parameter int MAX_TRACKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] depth_0_i,
  input  logic signed [31:0] depth_1_i,
  input  logic signed [31:0] depth_2_i,
  input  logic signed [31:0] depth_3_i,
  input  logic signed [31:0] depth_4_i,
  input  logic signed [31:0] depth_5_i,
  input  logic signed [31:0] depth_6_i,
  input  logic signed [31:0] depth_7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] combined_depth_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import mtdc_pkg::*;

  logic signed [DEPTH_W-1:0] depth_a [NUM_TRACKS];
  lane_t [NUM_TRACKS-1:0]    lanes;
  red_t                      red;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  mode_e                     mode_q;
  logic [COUNT_W-1:0]        count_q;
  logic [COUNT_W-1:0]        count_eff;
  logic [31:0]               prng_q, prng_d;
  logic [31:0]               lcg_next;
  state_e                    state_q, state_d;
  logic signed [DEPTH_W-1:0] res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DEPTH_W-1:0] out_data_q, out_data_d;
  logic                      in_fire;
  logic                      out_free;
  logic                      sum_neg;
  logic [SUM_W-1:0]          sum_mag;
  logic [RANGE_W-1:0]        range;
  logic [DEPTH_W-1:0]        mean_mag;

  assign depth_a = '{depth_0_i, depth_1_i, depth_2_i, depth_3_i,
                     depth_4_i, depth_5_i, depth_6_i, depth_7_i};

  // Track count clamped to one through MAX_TRACKS.
  always_comb begin
    if (count_q == '0) begin
      count_eff = COUNT_W'(1);
    end else if (count_q > COUNT_W'(MAX_TRACKS)) begin
      count_eff = COUNT_W'(MAX_TRACKS);
    end else begin
      count_eff = count_q;
    end
  end

  // Lanes exist for the tracks that can take part; the rest stay neutral.
  for (genvar j = 0; j < NUM_TRACKS; j++) begin : g_lane
    if (j < MAX_TRACKS) begin : g_on
      mtdc_lane #(
        .LANE(j)
      ) u_lane (
        .depth_i(depth_a[j]),
        .base_i (depth_0_i),
        .count_i(count_eff),
        .lane_o (lanes[j])
      );
    end else begin : g_off
      assign lanes[j].cmp = depth_0_i;
      assign lanes[j].add = '0;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  mtdc_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (in_fire),
    .lanes_i(lanes),
    .red_o  (red)
  );

  mtdc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Operands for the divider and the generator step.
  assign sum_neg  = red.sum[SUM_W-1];
  assign sum_mag  = sum_neg ? (SUM_W'(0) - red.sum) : red.sum;
  assign range    = RANGE_W'(red.hi) - RANGE_W'(red.lo) + RANGE_W'(1);
  assign lcg_next = 32'(prng_q * LCG_MUL) + LCG_ADD;
  assign mean_mag = div_rsp.quotient[DEPTH_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: evaluate, optionally step the generator and divide, then deliver.
  always_comb begin
    state_d          = state_q;
    res_d            = res_q;
    prng_d           = prng_q;
    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = DIV_W'(count_eff);
    out_valid_d      = out_valid_q;
    out_data_d       = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (mode_q)
          RULE_MIN: begin
            res_d   = red.lo;
            state_d = ST_DONE;
          end
          RULE_MAX: begin
            res_d   = red.hi;
            state_d = ST_DONE;
          end
          RULE_MEAN: begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end
          default: begin
            if (red.lo == red.hi) begin
              res_d   = red.lo;
              state_d = ST_DONE;
            end else begin
              prng_d  = lcg_next;
              state_d = ST_DRAW;
            end
          end
        endcase
      end
      ST_DRAW: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(prng_q[16 +: DRAW_W]);
        div_req.divisor  = DIV_W'(range);
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (mode_q == RULE_MEAN) begin
            res_d = sum_neg ? (DEPTH_W'(0) - mean_mag) : mean_mag;
          end else begin
            res_d = red.lo + div_rsp.remainder[DEPTH_W-1:0];
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A seed write reloads the generator.
    if (cfg_we_i && cfg_idx_i == CFG_SEED) begin
      prng_d = cfg_wdata_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= RULE_MIN;
      count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[1:0]);
        CFG_COUNT: count_q <= cfg_wdata_i[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Sequencer, generator and output handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prng_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prng_q      <= prng_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o      = out_valid_q;
  assign combined_depth_o = out_data_q;

endmodule

FILE: hw/rtl/mtdc_checker.sv
// Port-level checks of the depth combiner and their binding to the top level.
module mtdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] combined_depth_o
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Beats accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_fire && !out_fire) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(combined_depth_o))
    else $error("result changed while stalled");

  // The block works on one beat at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while a beat is in work");

  // A result is only offered for a beat that was accepted.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an accepted beat");

  // At most one finished result waits when a new beat is taken.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> pend_q <= 2'd1)
    else $error("too many beats outstanding");

endmodule

bind multi_track_depth_combiner_unit mtdc_checker u_mtdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .combined_depth_o(combined_depth_o)
);

FILE: verif/tb_multi_track_depth_combiner_unit.sv
// Self-checking testbench of the multi-track depth combiner: directed table, then random phases.
module tb_multi_track_depth_combiner_unit;
  import mtdc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 45;
  localparam int IDLE_PCT    = 27;

  localparam logic signed [DEPTH_W-1:0] D_MIN = 32'sh8000_0000;
  localparam logic signed [DEPTH_W-1:0] D_MAX = 32'sh7fff_ffff;

  typedef logic signed [DEPTH_W-1:0] depth_set_t [NUM_TRACKS];

  // One row of the directed table: optional register writes, then one beat.
  typedef struct {
    bit                        set_cfg;
    mode_e                     mode;
    logic [COUNT_W-1:0]        count;
    bit                        load_seed;
    logic [31:0]               seed;
    depth_set_t                depth;
    bit                        typed;
    logic signed [DEPTH_W-1:0] want;
  } stim_row_t;

  // Travels with each beat from driver to checker.
  typedef struct {
    bit                        typed;
    logic signed [DEPTH_W-1:0] want;
  } beat_hint_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [DEPTH_W-1:0] depth_0_i   = '0;
  logic signed [DEPTH_W-1:0] depth_1_i   = '0;
  logic signed [DEPTH_W-1:0] depth_2_i   = '0;
  logic signed [DEPTH_W-1:0] depth_3_i   = '0;
  logic signed [DEPTH_W-1:0] depth_4_i   = '0;
  logic signed [DEPTH_W-1:0] depth_5_i   = '0;
  logic signed [DEPTH_W-1:0] depth_6_i   = '0;
  logic signed [DEPTH_W-1:0] depth_7_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DEPTH_W-1:0] combined_depth_o;
  logic                      cfg_we_i    = 1'b0;
  logic [1:0]                cfg_idx_i   = '0;
  logic [31:0]               cfg_wdata_i = '0;

  multi_track_depth_combiner_unit #(
    .MAX_TRACKS(NUM_TRACKS)
  ) i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Mirror of the block's registers and generator state.
  mode_e              mdl_mode;
  logic [COUNT_W-1:0] mdl_count;
  logic [31:0]        lcg_state;

  logic signed [DEPTH_W-1:0] exp_depth_q [$];
  beat_hint_t                hint_q [$];
  stim_row_t                 rows [$];

  int beats_in     = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int missing      = 0;
  int settings     = 0;
  int quiet        = 0;
  int mode_beats [4] = '{0, 0, 0, 0};
  bit calm         = 1'b0;

  // Combined depth of one beat under the mirrored settings; steps the generator on a random draw.
  function automatic logic signed [DEPTH_W-1:0] predict_combined(input depth_set_t d);
    int          n;
    longint      lo, hi, sum, v, span;
    logic [31:0] nxt;
    n = int'(mdl_count);
    if (n < 1) n = 1;
    if (n > NUM_TRACKS) n = NUM_TRACKS;
    lo  = longint'(d[0]);
    hi  = lo;
    sum = lo;
    for (int j = 1; j < n; j++) begin
      v = longint'(d[j]);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      sum += v;
    end
    case (mdl_mode)
      RULE_MIN:  return DEPTH_W'(lo);
      RULE_MAX:  return DEPTH_W'(hi);
      RULE_MEAN: return DEPTH_W'(sum / longint'(n));
      default: begin
        if (lo == hi) return DEPTH_W'(lo);
        nxt       = lcg_state * LCG_MUL + LCG_ADD;
        lcg_state = nxt;
        span      = hi - lo + 1;
        return DEPTH_W'(lo + (longint'(nxt[30:16]) % span));
      end
    endcase
  endfunction

  // Random depths, mixing full-range noise with narrow and degenerate spreads.
  function automatic depth_set_t rand_depths();
    depth_set_t                d;
    logic signed [DEPTH_W-1:0] base;
    int                        spread;
    base = $urandom;
    case ($urandom_range(0, 5))
      0: foreach (d[j]) d[j] = $urandom;
      1: begin
        foreach (d[j]) begin
          case ($urandom_range(0, 4))
            0:       d[j] = D_MIN;
            1:       d[j] = D_MAX;
            2:       d[j] = 0;
            3:       d[j] = -1;
            default: d[j] = 1;
          endcase
        end
      end
      2: begin
        spread = $urandom_range(1, 20);
        foreach (d[j]) d[j] = base + $urandom_range(0, spread);
      end
      3: foreach (d[j]) d[j] = base;
      4: foreach (d[j]) d[j] = int'($urandom_range(0, 100)) - 50;
      default: foreach (d[j]) d[j] = base + $urandom_range(0, 40000);
    endcase
    return d;
  endfunction

  task automatic add_row(input bit set_cfg, input mode_e m, input logic [COUNT_W-1:0] c,
                         input bit ld, input logic [31:0] sd, input depth_set_t d,
                         input bit typed, input logic signed [DEPTH_W-1:0] want);
    stim_row_t r;
    r.set_cfg   = set_cfg;
    r.mode      = m;
    r.count     = c;
    r.load_seed = ld;
    r.seed      = sd;
    r.depth     = d;
    r.typed     = typed;
    r.want      = want;
    rows.push_back(r);
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (exp_depth_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input bit set_cfg, input mode_e m, input logic [COUNT_W-1:0] c,
                              input bit ld, input logic [31:0] sd);
    if (set_cfg || ld) begin
      settle();
      if (set_cfg) begin
        write_reg(CFG_MODE, {30'd0, m});
        write_reg(CFG_COUNT, {28'd0, c});
      end
      if (ld) write_reg(CFG_SEED, sd);
      cfg_we_i <= 1'b0;
      settings++;
    end
  endtask

  // Offer one beat after a random gap and hold it until it is taken.
  task automatic push_beat(input depth_set_t d, input bit typed,
                           input logic signed [DEPTH_W-1:0] want);
    beat_hint_t h;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    h.typed = typed;
    h.want  = want;
    hint_q.push_back(h);
    in_valid_i <= 1'b1;
    depth_0_i  <= d[0];
    depth_1_i  <= d[1];
    depth_2_i  <= d[2];
    depth_3_i  <= d[3];
    depth_4_i  <= d[4];
    depth_5_i  <= d[5];
    depth_6_i  <= d[6];
    depth_7_i  <= d[7];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Result side stalls at random except during the calm phase.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Mirror register writes, predict accepted beats, and check results in order.
  always @(posedge clk_i) begin
    depth_set_t                d;
    logic signed [DEPTH_W-1:0] pred;
    logic signed [DEPTH_W-1:0] want;
    beat_hint_t                h;
    if (!rst_ni) begin
      mdl_mode  = RULE_MIN;
      mdl_count = 4'd1;
      lcg_state = '0;
      quiet     = 0;
    end else begin
      quiet++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:  mdl_mode = mode_e'(cfg_wdata_i[1:0]);
          CFG_COUNT: mdl_count = cfg_wdata_i[COUNT_W-1:0];
          CFG_SEED:  lcg_state = cfg_wdata_i;
          default:   ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        d = '{depth_0_i, depth_1_i, depth_2_i, depth_3_i,
              depth_4_i, depth_5_i, depth_6_i, depth_7_i};
        mode_beats[int'(mdl_mode)]++;
        pred = predict_combined(d);
        h    = hint_q.pop_front();
        exp_depth_q.push_back(h.typed ? h.want : pred);
        beats_in++;
        quiet = 0;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        quiet = 0;
        if (exp_depth_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result %0d (0x%08h) with no beat pending",
                     combined_depth_o, combined_depth_o);
        end else begin
          want = exp_depth_q.pop_front();
          if (combined_depth_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                       results_seen, want, want, combined_depth_o, combined_depth_o);
          end
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("multi_track_depth_combiner_unit: mismatch");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then random phases with fresh settings.
  initial begin
    mode_e              m;
    logic [COUNT_W-1:0] c;

    // Reset settings: minimum over lane zero only.
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0,
            '{-7, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN}, 1, -7);
    // Extremes over all eight lanes.
    add_row(1, RULE_MIN, 4'd8, 0, 32'd0,
            '{0, 5, D_MAX, D_MIN, -1, 1, 100, -100}, 1, D_MIN);
    add_row(1, RULE_MAX, 4'd8, 0, 32'd0,
            '{0, 5, D_MAX, D_MIN, -1, 1, 100, -100}, 1, D_MAX);
    add_row(1, RULE_MEAN, 4'd8, 0, 32'd0,
            '{D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX}, 1, D_MAX);
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0,
            '{D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN}, 1, D_MIN);
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0,
            '{D_MAX, D_MAX, D_MIN, 3, -9, D_MAX, 0, -1}, 0, 0);
    // Mean truncates toward zero for negative sums.
    add_row(1, RULE_MEAN, 4'd3, 0, 32'd0, '{-7, 0, 0, 99, 99, 99, 99, 99}, 1, -2);
    add_row(1, RULE_MEAN, 4'd2, 0, 32'd0, '{D_MIN, D_MAX, 5, 5, 5, 5, 5, 5}, 1, 0);
    add_row(1, RULE_MEAN, 4'd7, 0, 32'd0, '{1, 2, 3, 4, 5, 6, 8, 1000}, 0, 0);
    // A count of zero acts as one; counts above eight saturate.
    add_row(1, RULE_MAX, 4'd0, 0, 32'd0, '{3, 100, 100, 100, 100, 100, 100, 100}, 1, 3);
    add_row(1, RULE_MIN, 4'd15, 0, 32'd0, '{0, 0, 0, 0, 0, 0, 0, -100}, 1, -100);
    add_row(1, RULE_MAX, 4'd9, 0, 32'd0, '{0, 0, 0, 0, 0, 0, 0, 77}, 1, 77);
    // Random mode: equal bounds return the bound without a draw.
    add_row(1, RULE_RAND, 4'd4, 1, 32'd0, '{42, 42, 42, 42, 1, 2, 3, 4}, 1, 42);
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0, '{10, 11, 12, 13, 0, 0, 0, 0}, 0, 0);
    // Full range wider than the draw can reach.
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0, '{D_MIN, D_MAX, 0, 0, 0, 0, 0, 0}, 0, 0);
    add_row(1, RULE_RAND, 4'd2, 1, 32'hffff_ffff, '{5, 6, 0, 0, 0, 0, 0, 0}, 0, 0);
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0, '{6, 5, 9, 9, 9, 9, 9, 9}, 0, 0);
    add_row(0, RULE_MIN, 4'd0, 0, 32'd0, '{-1, -1, 0, 7, 7, 7, 7, 7}, 1, -1);
    add_row(1, RULE_RAND, 4'd8, 1, 32'd12345, '{0, 1, 2, 3, 4, 5, 6, 70000}, 0, 0);
    add_row(1, RULE_MIN, 4'd1, 0, 32'd0,
            '{D_MAX, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN}, 1, D_MAX);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      program_regs(rows[i].set_cfg, rows[i].mode, rows[i].count,
                   rows[i].load_seed, rows[i].seed);
      push_beat(rows[i].depth, rows[i].typed, rows[i].want);
    end

    // Early phases pin each rule to an extreme count; the rest are drawn at random.
    for (int p = 0; p < PHASES; p++) begin
      m = (p < 4) ? mode_e'(p) : mode_e'($urandom_range(0, 3));
      case (p)
        0:       c = 4'd8;
        1:       c = 4'd1;
        2:       c = 4'd0;
        3:       c = 4'd15;
        default: c = COUNT_W'($urandom_range(0, 15));
      endcase
      program_regs(1, m, c, (m == RULE_RAND) || ($urandom_range(0, 3) == 0), $urandom);
      calm = (p == 6);
      repeat (PHASE_BEATS) push_beat(rand_depths(), 0, '0);
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    missing = exp_depth_q.size();
    if (missing != 0) $display("%0d expected results never arrived", missing);

    $display("Covered %0d beats and %0d results over %0d register settings.",
             beats_in, results_seen, settings);
    $display("Beats per rule: min %0d, max %0d, mean %0d, random %0d; %0d bad results.",
             mode_beats[0], mode_beats[1], mode_beats[2], mode_beats[3], mismatches);
    if (mismatches == 0 && missing == 0) begin
      $display("multi_track_depth_combiner_unit: match");
    end else begin
      $display("multi_track_depth_combiner_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mtdc_pkg.sv
hw/rtl/mtdc_lane.sv
hw/rtl/mtdc_merge.sv
hw/rtl/mtdc_div.sv
hw/rtl/multi_track_depth_combiner_unit.sv
hw/rtl/mtdc_checker.sv
verif/tb_multi_track_depth_combiner_unit.sv
